>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: a |-> b");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: a |=> b");

`endif

>>> rtl/mfem_pkg.sv
// Package for the Mersenne factor exponent marker.
// Holds codes, state type and the controller/datapath interface structs.
`timescale 1ns / 1ps
package mfem_pkg;

  localparam int MAX_EXPONENT_DEF = 65536;
  localparam int FACTOR_BITS_DEF  = 64;
  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  // Request types
  localparam logic [1:0] REQ_TEST = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Configuration register indexes
  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_PRIME = 1'b1;

  typedef enum logic [2:0] {
    OUT_MERSENNE  = 3'd0,
    OUT_RESIDUE   = 3'd1,
    OUT_COMPOSITE = 3'd2,
    OUT_NOT_PRIME = 3'd3,
    OUT_MARKED    = 3'd4,
    OUT_LOADED    = 3'd5,
    OUT_READ      = 3'd6
  } outcome_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DIV_EVAL,
    S_ORD_INIT,
    S_ORD_STEP,
    S_MEM_RD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic     clr_wr;
    logic     latch;
    logic     div_start;
    logic     d_init;
    logic     d_adv;
    logic     ord_init;
    logic     ord_step;
    logic     mem_rd;
    logic     out_load;
    outcome_t outcome;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] req;
    logic       mersenne;
    logic       res_ok;
    logic       need_prime;
    logic       div_busy;
    logic       div_gt;
    logic       rem_zero;
    logic       ord_run;
    logic       comp_bit;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/mfem_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for trial division; no package dependency.
`timescale 1ns / 1ps
module mfem_div #(
  parameter int QW = 63,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt;
  logic [QW-1:0] dvd;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          ge;

  // Shift in the next dividend bit and compare
  always_comb begin
    trial = {rem, dvd[QW-1]};
    ge    = trial >= {1'b0, dvs};
  end

  // Control: busy flag and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      quot <= {quot[QW-2:0], ge};
      rem  <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
    end
  end
endmodule

>>> rtl/mfem_datapath.sv
// Datapath: input latch, config registers, trial-division divisor, order
// search, bitmap memories and output register. Uses mfem_pkg and mfem_div.
`timescale 1ns / 1ps
module mfem_datapath #(
  parameter int MAX_EXPONENT = 65536,
  parameter int FACTOR_BITS  = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mfem_pkg::cmd_t           cmd,
  output mfem_pkg::sts_t           sts,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [16:0]              cfg_data,
  input  logic [1:0]               in_req,
  input  logic [FACTOR_BITS-2:0]   in_factor,
  input  logic [10:0]              in_idx,
  input  logic [31:0]              in_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output mfem_pkg::outcome_t       out_outcome,
  output logic [15:0]              out_exponent,
  output logic [31:0]              out_data
);
  import mfem_pkg::*;

  localparam int QW        = FACTOR_BITS - 1;
  localparam int DW        = FACTOR_BITS / 2 + 1;
  localparam int RW        = FACTOR_BITS;
  localparam int MAP_WORDS = MAX_EXPONENT / 32;
  localparam int MAW       = $clog2(MAP_WORDS);
  localparam int KW        = $clog2(MAX_EXPONENT + 1);

  // Request latch and config
  logic [1:0]    req_r;
  logic [QW-1:0] q_r;
  logic [10:0]   idx_r;
  logic [31:0]   data_r;
  logic [16:0]   limit_r;
  logic          need_r;

  // Trial division and order search
  logic [DW-1:0] d_r;
  logic [QW-1:0] quot;
  logic [DW-1:0] rem;
  logic          div_busy;
  logic [RW-1:0] r_r;
  logic [RW-1:0] r_sum;
  logic [RW-1:0] r_nx;
  logic [KW-1:0] k_r;
  logic [KW-1:0] k_nx;
  logic [KW-1:0] n_r;
  logic [KW-1:0] bnd_m1_r;
  logic [KW-1:0] bound;
  logic          found_r;
  logic [31:0]   lim32;
  logic [31:0]   sat32;
  logic          q_lt;

  // Memories
  logic [31:0]    elim_mem [MAP_WORDS];
  logic [31:0]    comp_mem [MAP_WORDS];
  logic [31:0]    elim_q;
  logic [31:0]    comp_q;
  logic [MAW-1:0] clr_cnt;
  logic [MAW-1:0] idx_addr;
  logic [MAW-1:0] n_addr;
  logic [MAW-1:0] rd_addr;
  logic           idx_in;
  logic [31:0]    n32;

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req;
      q_r    <= in_factor;
      idx_r  <= in_idx;
      data_r <= in_data;
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_r <= LIMIT_RESET;
      need_r  <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LIMIT) limit_r <= cfg_data;
      if (cfg_index == CFG_PRIME) need_r  <= cfg_data[0];
    end
  end

  // Trial divisor: start at 3, advance by 2
  always_ff @(posedge clk) begin
    if (cmd.d_init)     d_r <= DW'(3);
    else if (cmd.d_adv) d_r <= d_r + DW'(2);
  end

  mfem_div #(.QW(QW), .DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (q_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  // Order search bound: min(q, saturated limit), minus one
  always_comb begin
    lim32 = {15'b0, limit_r};
    sat32 = (lim32 > 32'(MAX_EXPONENT)) ? 32'(MAX_EXPONENT) : lim32;
    q_lt  = 64'(q_r) < 64'(sat32);
    bound = q_lt ? KW'(q_r) : KW'(sat32);
    r_sum = r_r[0] ? r_r + RW'(q_r) : r_r;
    r_nx  = r_sum >> 1;
    k_nx  = k_r + 1'b1;
  end

  // Halving step: r = (r odd ? r + q : r) / 2
  always_ff @(posedge clk) begin
    if (cmd.ord_init) begin
      r_r      <= RW'(1);
      k_r      <= '0;
      n_r      <= '0;
      found_r  <= 1'b0;
      bnd_m1_r <= (bound == '0) ? '0 : bound - 1'b1;
    end else if (cmd.ord_step) begin
      r_r <= r_nx;
      k_r <= k_nx;
      if (r_nx == RW'(1)) begin
        n_r     <= k_nx;
        found_r <= 1'b1;
      end
    end
  end

  // Bitmap addressing
  always_comb begin
    idx_in   = 32'(idx_r) < 32'(MAP_WORDS);
    idx_addr = MAW'(idx_r);
    n_addr   = MAW'(n_r >> 5);
    rd_addr  = (req_r == REQ_TEST) ? n_addr : idx_addr;
    n32      = 32'(n_r);
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst)             clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
  end

  // Record bitmap: clear, registered read, mark
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      elim_mem[clr_cnt] <= '0;
    end else if (cmd.out_load && cmd.outcome == OUT_MARKED) begin
      elim_mem[n_addr] <= elim_q | (32'd1 << n_r[4:0]);
    end
    if (cmd.mem_rd) elim_q <= elim_mem[rd_addr];
  end

  // Composite bitmap: load, registered read
  always_ff @(posedge clk) begin
    if (cmd.out_load && cmd.outcome == OUT_LOADED && idx_in) begin
      comp_mem[idx_addr] <= data_r;
    end
    if (cmd.mem_rd) comp_q <= comp_mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome  <= cmd.outcome;
      out_exponent <= (cmd.outcome == OUT_NOT_PRIME || cmd.outcome == OUT_MARKED)
                      ? n32[15:0] : 16'd0;
      out_data     <= (cmd.outcome == OUT_READ && idx_in) ? elim_q : 32'd0;
    end
  end

  // Status to controller
  always_comb begin
    sts.clr_last   = clr_cnt == MAW'(MAP_WORDS - 1);
    sts.req        = req_r;
    sts.mersenne   = (q_r & (q_r + 1'b1)) == '0;
    sts.res_ok     = q_r[2:0] == 3'd1 || q_r[2:0] == 3'd7;
    sts.need_prime = need_r;
    sts.div_busy   = div_busy;
    sts.div_gt     = QW'(d_r) > quot;
    sts.rem_zero   = rem == '0;
    sts.ord_run    = !found_r && (k_r < bnd_m1_r);
    sts.comp_bit   = comp_q[n_r[4:0]];
    sts.out_free   = !out_valid || out_ready;
  end
endmodule

>>> rtl/mfem_ctrl.sv
// Controller state machine for the Mersenne factor exponent marker.
// Sequences the datapath through commands; uses mfem_pkg.
`timescale 1ns / 1ps
module mfem_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mfem_pkg::sts_t sts,
  output mfem_pkg::cmd_t cmd
);
  import mfem_pkg::*;

  state_t   state;
  state_t   state_next;
  outcome_t outcome;
  outcome_t outcome_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      outcome <= OUT_MERSENNE;
    end else begin
      state   <= state_next;
      outcome <= outcome_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    outcome_next = outcome;
    unique case (state)
      S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (sts.req)
          REQ_LOAD: begin
            outcome_next = OUT_LOADED;
            state_next   = S_FINISH;
          end
          REQ_READ: begin
            outcome_next = OUT_READ;
            state_next   = S_MEM_RD;
          end
          REQ_TEST: begin
            priority if (sts.mersenne) begin
              outcome_next = OUT_MERSENNE;
              state_next   = S_FINISH;
            end else if (!sts.res_ok) begin
              outcome_next = OUT_RESIDUE;
              state_next   = S_FINISH;
            end else if (sts.need_prime) begin
              state_next = S_DIV_GO;
            end else begin
              state_next = S_ORD_INIT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (!sts.div_busy) state_next = S_DIV_EVAL;
      S_DIV_EVAL: begin
        priority if (sts.div_gt) begin
          state_next = S_ORD_INIT;
        end else if (sts.rem_zero) begin
          outcome_next = OUT_COMPOSITE;
          state_next   = S_FINISH;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_ORD_INIT: state_next = S_ORD_STEP;
      S_ORD_STEP: begin
        if (!sts.ord_run) begin
          outcome_next = OUT_MARKED;
          state_next   = S_MEM_RD;
        end
      end
      S_MEM_RD:   state_next = S_FINISH;
      S_FINISH:   if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.outcome = outcome;
    in_ready    = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DECODE:   cmd.d_init = 1'b1;
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: ;
      S_DIV_EVAL: cmd.d_adv = 1'b1;
      S_ORD_INIT: cmd.ord_init = 1'b1;
      S_ORD_STEP: cmd.ord_step = sts.ord_run;
      S_MEM_RD:   cmd.mem_rd = 1'b1;
      S_FINISH: begin
        cmd.out_load = sts.out_free;
        if (outcome == OUT_MARKED && sts.comp_bit) cmd.outcome = OUT_NOT_PRIME;
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/mersenne_factor_exponent_marker_unit.sv
// Top level of the Mersenne factor exponent marker.
// Joins mfem_ctrl and mfem_datapath; uses mfem_pkg.
`timescale 1ns / 1ps
// After reset the record bitmap is cleared one word a cycle, all MAX_EXPONENT/32
// words (2048 by default), before the first transaction is taken. A load
// request goes from decode to finish; a read request adds a bitmap read. A
// test request skipped by form or residue goes from decode to finish; with
// prime checking on, each trial divisor runs through the bit-serial divider,
// up to sqrt(q)/2 divisors; then the order search runs halving steps, up to
// min(q, limit capped at MAX_EXPONENT) - 1 of them, then a bitmap read and,
// unless the exponent's composite bit is set, a mark write. The result sits
// in an output register, so the next request is taken while it waits.
module mersenne_factor_exponent_marker_unit #(
  parameter int MAX_EXPONENT = mfem_pkg::MAX_EXPONENT_DEF,
  parameter int FACTOR_BITS  = mfem_pkg::FACTOR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // factor, word_index, word_data (from bit 0 up), zero fill
  input  logic [((FACTOR_BITS-1+43+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // exponent, read_data (from bit 0 up)
  output logic [47:0] m_tdata,
  // outcome
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import mfem_pkg::*;

  localparam int QW = FACTOR_BITS - 1;

  cmd_t     cmd;
  sts_t     sts;
  outcome_t out_outcome;
  logic [15:0] out_exponent;
  logic [31:0] out_data;

  mfem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfem_datapath #(
    .MAX_EXPONENT (MAX_EXPONENT),
    .FACTOR_BITS  (FACTOR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req       (s_tuser),
    .in_factor    (s_tdata[QW-1:0]),
    .in_idx       (s_tdata[QW+10:QW]),
    .in_data      (s_tdata[QW+42:QW+11]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_outcome  (out_outcome),
    .out_exponent (out_exponent),
    .out_data     (out_data)
  );

  assign m_tdata = {out_data, out_exponent};
  assign m_tuser = out_outcome;
endmodule

>>> rtl/mfem_checker.sv
// Port-level checker for the Mersenne factor exponent marker, with bind.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfem_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import mfem_pkg::*;

  logic is_read;
  logic has_exp;

  // Decode the result kind
  assign is_read = m_tuser == OUT_READ;
  assign has_exp = m_tuser == OUT_NOT_PRIME || m_tuser == OUT_MARKED;

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // Record data only for read results
  `ASSERT_IMPLY(a_read_data_zero, clk, rst, m_tvalid && !is_read, m_tdata[47:16] == 32'd0)

  // Exponent only for exponent lookups
  `ASSERT_IMPLY(a_exp_zero, clk, rst, m_tvalid && !has_exp, m_tdata[15:0] == 16'd0)
endmodule

bind mersenne_factor_exponent_marker_unit mfem_checker u_mfem_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/mfem_scoreboard.sv
// Checker for the Mersenne factor exponent marker: watches the request, result
// and register ports, predicts every result and compares it. Uses mfem_pkg.
`timescale 1ns / 1ps
module mfem_scoreboard #(
  parameter int MAX_EXPONENT = mfem_pkg::MAX_EXPONENT_DEF,
  parameter int FACTOR_BITS  = mfem_pkg::FACTOR_BITS_DEF,
  parameter int TDW          = ((FACTOR_BITS-1+43+7)/8)*8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tready,
  input  logic [TDW-1:0] s_tdata,
  input  logic [1:0]     s_tuser,
  input  logic           m_tvalid,
  input  logic           m_tready,
  input  logic [47:0]    m_tdata,
  input  logic [2:0]     m_tuser,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [16:0]    cfg_data,
  output int             fail_count,
  output int             pending
);
  import mfem_pkg::*;

  localparam int WORDS = MAX_EXPONENT / 32;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] exponent;
    logic [31:0] read_data;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic [31:0] record_map[WORDS];
  logic [31:0] comp_map[WORDS];
  logic [16:0] limit_reg;
  logic        prime_reg;

  assign pending = verdict_q.size();

  // Trial division by odd divisors up to the square root
  function automatic bit is_prime_odd(longint unsigned q);
    longint unsigned d;
    if (q < 2) return 0;
    if (q == 2) return 1;
    if (q[0] == 1'b0) return 0;
    for (d = 3; d <= q / d; d += 2)
      if (q % d == 0) return 0;
    return 1;
  endfunction

  // Order of 2 modulo q by halving, 0 when not below the bound
  function automatic int unsigned order_of_two(longint unsigned q, int unsigned lim);
    longint unsigned bound, r;
    int unsigned k;
    bound = (q < 64'(lim)) ? q : 64'(lim);
    r = 1;
    k = 0;
    while (bound > 0 && k < bound - 1) begin
      if (r[0]) r += q;
      r >>= 1;
      k++;
      if (r == 1) return k;
    end
    return 0;
  endfunction

  function automatic verdict_t predict_request(logic [1:0] rq, logic [TDW-1:0] d);
    verdict_t v;
    longint unsigned q;
    logic [10:0] wi;
    int unsigned lim, n;
    v = '0;
    q = {1'b0, d[62:0]};
    wi = d[73:63];
    case (rq)
      REQ_LOAD: begin
        if (wi < WORDS) comp_map[wi] = d[105:74];
        v.outcome = OUT_LOADED;
      end
      REQ_READ: begin
        if (wi < WORDS) v.read_data = record_map[wi];
        v.outcome = OUT_READ;
      end
      default: begin
        if ((q & (q + 1)) == 0) v.outcome = OUT_MERSENNE;
        else if (q[2:0] != 3'd1 && q[2:0] != 3'd7) v.outcome = OUT_RESIDUE;
        else if (prime_reg && !is_prime_odd(q)) v.outcome = OUT_COMPOSITE;
        else begin
          lim = 32'(limit_reg);
          if (lim > MAX_EXPONENT) lim = MAX_EXPONENT;
          n = order_of_two(q, lim);
          if (n >= MAX_EXPONENT) n = 0;
          v.exponent = n[15:0];
          if (comp_map[n[15:5]][n[4:0]]) v.outcome = OUT_NOT_PRIME;
          else begin
            record_map[n[15:5]][n[4:0]] = 1'b1;
            v.outcome = OUT_MARKED;
          end
        end
      end
    endcase
    return v;
  endfunction

  // Reset the model, else compare results first, then track registers and requests
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      fail_count = 0;
      limit_reg = LIMIT_RESET;
      prime_reg = 1'b1;
      verdict_q.delete();
      for (int i = 0; i < WORDS; i++) begin
        record_map[i] = '0;
        comp_map[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result outcome %0d data %h", $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tuser != want.outcome) begin
            $display("%0t outcome expected %0d actual %0d", $time, want.outcome, m_tuser);
            fail_count++;
          end
          if (m_tdata[15:0] != want.exponent) begin
            $display("%0t exponent expected %0d actual %0d", $time, want.exponent,
                     m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[47:16] != want.read_data) begin
            $display("%0t read_data expected %h actual %h", $time, want.read_data,
                     m_tdata[47:16]);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LIMIT) limit_reg = cfg_data;
        else prime_reg = cfg_data[0];
      end
      if (s_tvalid && s_tready && s_tuser != REQ_NONE)
        verdict_q.push_back(predict_request(s_tuser, s_tdata));
    end
  end

  final begin
    if (verdict_q.size() != 0)
      $display("%0t %0d results never arrived", $time, verdict_q.size());
  end
endmodule

>>> dv/mersenne_factor_exponent_marker_unit_test.sv
// Testbench top for the Mersenne factor exponent marker: clock, reset,
// stimulus and verdict. Depends on mfem_pkg, the block and mfem_scoreboard.
`timescale 1ns / 1ps
module mersenne_factor_exponent_marker_unit_test;
  import mfem_pkg::*;

  localparam int TDW = ((FACTOR_BITS_DEF-1+43+7)/8)*8;
  localparam int STALL_LIMIT = 300000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [TDW-1:0] s_tdata = '0;
  logic [1:0]     s_tuser = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [47:0]    m_tdata;
  logic [2:0]     m_tuser;
  logic           cfg_we = 1'b0;
  logic           cfg_index = 1'b0;
  logic [16:0]    cfg_data = '0;
  int             fail_count;
  int             pending;
  int             tx_idle = 0;
  int             rx_idle = 0;
  int             hold_seq = 0;
  int             quiet_cycles = 0;

  mersenne_factor_exponent_marker_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data
  );

  mfem_scoreboard i_scoreboard (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random backpressure, plus a long hold-off on request
  initial begin
    int seen, hold_left;
    seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("mersenne_factor_exponent_marker_unit_test failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] rq, logic [62:0] q, logic [10:0] wi,
                           logic [31:0] wd);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rq;
    s_tdata <= {{(TDW-106){1'b0}}, wd, wi, q};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic idx, logic [16:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Build one random request; big factors only when they stay cheap
  task automatic random_item(bit big_ok);
    int pick;
    logic [62:0] q;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_item(REQ_LOAD, 63'($urandom) << 31, 11'($urandom), $urandom);
    end else if (pick < 25) begin
      send_item(REQ_READ, 63'($urandom), 11'($urandom), $urandom);
    end else if (pick < 30) begin
      send_item(REQ_NONE, 63'({$urandom, $urandom}), 11'($urandom), $urandom);
    end else begin
      q = 63'({$urandom, $urandom});
      if (big_ok) begin
        if ($urandom_range(1)) q[2:0] = $urandom_range(1) ? 3'd1 : 3'd7;
      end else if ($urandom_range(4) == 0) begin
        // large composite: a multiple of three fails at the first divisor
        q = q - (q % 3);
      end else begin
        // small factor: its order stays inside the preloaded words
        q = 63'($urandom_range(31)) << 3;
        q[2:0] = ($urandom_range(9) == 0) ? 3'($urandom) :
                 ($urandom_range(1) ? 3'd1 : 3'd7);
      end
      send_item(REQ_TEST, q, 11'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Preload the composite words that exponents below 256 use; word 0
    // marks only exponent 11
    tx_idle = 28;
    rx_idle = 67;
    write_reg(CFG_LIMIT, LIMIT_RESET);
    write_reg(CFG_PRIME, 17'd1);
    send_item(REQ_LOAD, '0, 11'd0, 32'h0000_0800);
    for (int i = 1; i < 8; i++) send_item(REQ_LOAD, '0, 11'(i), $urandom);

    // Directed: forms, residues, composites, marks, reads, unused type
    send_item(REQ_TEST, 63'd0, '0, '0);
    send_item(REQ_TEST, 63'd1, '0, '0);
    send_item(REQ_TEST, 63'd7, '0, '0);
    send_item(REQ_TEST, {63{1'b1}}, '0, '0);
    send_item(REQ_TEST, 63'd5, '0, '0);
    send_item(REQ_TEST, 63'h4000_0000_0000_0000, '0, '0);
    send_item(REQ_TEST, 63'd49, '0, '0);
    send_item(REQ_TEST, 63'd119, '0, '0);
    send_item(REQ_TEST, 63'd23, '0, '0);
    send_item(REQ_TEST, 63'd47, '0, '0);
    send_item(REQ_TEST, 63'd73, '0, '0);
    send_item(REQ_TEST, 63'd17, '0, '0);
    send_item(REQ_READ, '0, 11'd0, '0);
    send_item(REQ_READ, '0, 11'd2047, '0);
    send_item(REQ_NONE, '0, '0, '0);
    write_reg(CFG_PRIME, 17'd0);
    write_reg(CFG_LIMIT, 17'd256);
    send_item(REQ_TEST, 63'h4000_0000_0000_0001, '0, '0);
    send_item(REQ_TEST, 63'h7FFF_FFFF_FFFF_FFF7, '0, '0);
    write_reg(CFG_LIMIT, 17'd2);
    send_item(REQ_TEST, 63'd73, '0, '0);
    write_reg(CFG_LIMIT, 17'd0);
    send_item(REQ_TEST, 63'd47, '0, '0);
    write_reg(CFG_LIMIT, 17'd1);
    send_item(REQ_TEST, 63'd23, '0, '0);
    send_item(REQ_READ, '0, 11'd0, '0);

    // Fill the block while the result side holds off
    hold_seq++;
    for (int i = 0; i < 8; i++) send_item(REQ_READ, '0, 11'(i), '0);

    // Phase one: prime checking, full limit, slow receiver
    write_reg(CFG_LIMIT, LIMIT_RESET);
    write_reg(CFG_PRIME, 17'd1);
    tx_idle = 28;
    rx_idle = 67;
    for (int i = 0; i < 20; i++) random_item(1'b0);

    // Phase two: no prime checking, short limit, wide factors
    write_reg(CFG_PRIME, 17'd0);
    write_reg(CFG_LIMIT, 17'd256);
    tx_idle = 67;
    rx_idle = 28;
    for (int i = 0; i < 20; i++) random_item(1'b1);

    // Phase three: saturating limit, no idling
    write_reg(CFG_LIMIT, 17'h1FFFF);
    write_reg(CFG_PRIME, 17'd1);
    tx_idle = 0;
    rx_idle = 0;
    for (int i = 0; i < 20; i++) random_item(1'b0);
    for (int i = 0; i < 8; i++) send_item(REQ_READ, '0, 11'(i), '0);

    // Drain
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("mersenne_factor_exponent_marker_unit_test passed");
    end else begin
      $display("mersenne_factor_exponent_marker_unit_test failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/mfem_pkg.sv
rtl/mfem_div.sv
rtl/mfem_datapath.sv
rtl/mfem_ctrl.sv
rtl/mersenne_factor_exponent_marker_unit.sv
rtl/mfem_checker.sv
dv/mfem_scoreboard.sv
dv/mersenne_factor_exponent_marker_unit_test.sv
